### rtl/assert_macros.svh
// Assertion helpers for the allocator checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/cba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants of the contiguous block allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam int NUM_BLOCKS = 128;
  localparam int IDX_W   = 7;
  localparam int CNT_W   = 8;
  localparam int BS_W    = 16;
  localparam int BYTES_W = 23;
  localparam int ENT_W   = 3 + CNT_W;  // used, multi, start, run count

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_BADINDEX = 2'd2;

  localparam logic [BS_W-1:0] BLOCK_SIZE_RST = 16'd16;

  typedef enum logic [4:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_DISPATCH,
    CS_ARD,
    CS_AEV,
    CS_MARK,
    CS_NRD,
    CS_NEV,
    CS_FRD,
    CS_FEV,
    CS_WRD,
    CS_WEV,
    CS_REL,
    CS_FFIN,
    CS_RESP
  } ctl_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_ERR_NOSPACE,
    OP_ERR_BAD,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_FOUND,
    OP_MARK,
    OP_NF_STEP,
    OP_NF_SET,
    OP_NF_FULL,
    OP_FIND_INIT,
    OP_WALK_BACK,
    OP_WALK_DONE,
    OP_REL,
    OP_FREE_FIN,
    OP_RESP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       cnt_bad;
    logic       ff_full;
    logic       idx_bad;
    logic       used;
    logic       start_or_zero;
    logic       run_hit;
    logic       at_end;
    logic       rem_last;
    logic       len_zero;
    logic       start_is_ff;
    logic       out_free;
  } dp_status_t;

endpackage

### rtl/contiguous_block_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_block_allocator_unit
// First-fit allocator over one pool of fixed-size blocks.
// ----------------------------------------------------------------------------
// One item at a time; the block table is a single-port memory with a
// registered read, so each examined block passes through a read state and
// an evaluate state. Allocate scans from the hint, marks the run and, if
// the run began at the hint, scans on for the new hint; free and query walk
// back to the run's start, and free then releases each block of the run.
// After reset a clearing pass over all NUM_BLOCKS entries runs before the
// first item is taken; the block size register is writable at any time. A
// result waits in an output register.
module contiguous_block_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  func_i,
  input  logic [cba_pkg::CNT_W-1:0]   count_i,
  input  logic [cba_pkg::IDX_W-1:0]   block_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [cba_pkg::IDX_W-1:0]   start_index_o,
  output logic [cba_pkg::CNT_W-1:0]   run_length_o,
  output logic [cba_pkg::BYTES_W-1:0] run_bytes_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cba_pkg::BS_W-1:0]    cfg_block_size_i
);

  cba_pkg::dp_cmd_t    cmd;
  cba_pkg::dp_status_t st;

  assign cfg_ready_o = 1'b1;

  cba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  cba_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .st_o             (st),
    .func_i           (func_i),
    .count_i          (count_i),
    .block_index_i    (block_index_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_block_size_i (cfg_block_size_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .start_index_o    (start_index_o),
    .run_length_o     (run_length_o),
    .run_bytes_o      (run_bytes_o)
  );

endmodule

### rtl/cba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_ctrl
// Sequencer: clearing pass, first-fit scan, marking, run walk and release.
// ----------------------------------------------------------------------------
module cba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cba_pkg::dp_status_t st_i,
  output cba_pkg::dp_cmd_t    cmd_o
);

  cba_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cba_pkg::CS_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = cba_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      cba_pkg::CS_CLEAR: begin
        cmd_o.op = cba_pkg::OP_CLR;
        if (st_i.at_end) state_d = cba_pkg::CS_IDLE;
      end
      cba_pkg::CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = cba_pkg::OP_LOAD;
          state_d  = cba_pkg::CS_DISPATCH;
        end
      end
      cba_pkg::CS_DISPATCH: begin
        if (st_i.func == cba_pkg::FUNC_ALLOC) begin
          if (st_i.cnt_bad || st_i.ff_full) begin
            cmd_o.op = cba_pkg::OP_ERR_NOSPACE;
            state_d  = cba_pkg::CS_RESP;
          end else begin
            cmd_o.op = cba_pkg::OP_SCAN_INIT;
            state_d  = cba_pkg::CS_ARD;
          end
        end else if ((st_i.func == cba_pkg::FUNC_FREE ||
                      st_i.func == cba_pkg::FUNC_QUERY) && !st_i.idx_bad) begin
          cmd_o.op = cba_pkg::OP_FIND_INIT;
          state_d  = cba_pkg::CS_FRD;
        end else begin
          cmd_o.op = cba_pkg::OP_ERR_BAD;
          state_d  = cba_pkg::CS_RESP;
        end
      end
      cba_pkg::CS_ARD: state_d = cba_pkg::CS_AEV;
      cba_pkg::CS_AEV: begin
        if (st_i.run_hit) begin
          cmd_o.op = cba_pkg::OP_FOUND;
          state_d  = cba_pkg::CS_MARK;
        end else if (st_i.at_end) begin
          cmd_o.op = cba_pkg::OP_ERR_NOSPACE;
          state_d  = cba_pkg::CS_RESP;
        end else begin
          cmd_o.op = cba_pkg::OP_SCAN_STEP;
          state_d  = cba_pkg::CS_ARD;
        end
      end
      cba_pkg::CS_MARK: begin
        cmd_o.op = cba_pkg::OP_MARK;
        if (st_i.rem_last) begin
          // hint moves only if the run began at it
          if (st_i.start_is_ff && !st_i.at_end) state_d = cba_pkg::CS_NRD;
          else                                  state_d = cba_pkg::CS_RESP;
        end
      end
      cba_pkg::CS_NRD: state_d = cba_pkg::CS_NEV;
      cba_pkg::CS_NEV: begin
        if (!st_i.used) begin
          cmd_o.op = cba_pkg::OP_NF_SET;
          state_d  = cba_pkg::CS_RESP;
        end else if (st_i.at_end) begin
          cmd_o.op = cba_pkg::OP_NF_FULL;
          state_d  = cba_pkg::CS_RESP;
        end else begin
          cmd_o.op = cba_pkg::OP_NF_STEP;
          state_d  = cba_pkg::CS_NRD;
        end
      end
      cba_pkg::CS_FRD: state_d = cba_pkg::CS_FEV;
      cba_pkg::CS_WRD: state_d = cba_pkg::CS_WEV;
      cba_pkg::CS_FEV, cba_pkg::CS_WEV: begin
        if (state_q == cba_pkg::CS_FEV && !st_i.used) begin
          cmd_o.op = cba_pkg::OP_ERR_BAD;
          state_d  = cba_pkg::CS_RESP;
        end else if (st_i.start_or_zero) begin
          cmd_o.op = cba_pkg::OP_WALK_DONE;
          if (st_i.func != cba_pkg::FUNC_FREE) state_d = cba_pkg::CS_RESP;
          else if (st_i.len_zero)              state_d = cba_pkg::CS_FFIN;
          else                                 state_d = cba_pkg::CS_REL;
        end else begin
          cmd_o.op = cba_pkg::OP_WALK_BACK;
          state_d  = cba_pkg::CS_WRD;
        end
      end
      cba_pkg::CS_REL: begin
        cmd_o.op = cba_pkg::OP_REL;
        if (st_i.rem_last) state_d = cba_pkg::CS_FFIN;
      end
      cba_pkg::CS_FFIN: begin
        cmd_o.op = cba_pkg::OP_FREE_FIN;
        state_d  = cba_pkg::CS_RESP;
      end
      cba_pkg::CS_RESP: begin
        if (st_i.out_free) begin
          cmd_o.op = cba_pkg::OP_RESP;
          state_d  = cba_pkg::CS_IDLE;
        end
      end
      default: state_d = cba_pkg::CS_IDLE;
    endcase
  end

endmodule

### rtl/cba_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_datapath
// Block table memory, scan/walk address, hint, usage total and result register.
// ----------------------------------------------------------------------------
module cba_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cba_pkg::dp_cmd_t              cmd_i,
  output cba_pkg::dp_status_t           st_o,
  input  logic [1:0]                    func_i,
  input  logic [cba_pkg::CNT_W-1:0]     count_i,
  input  logic [cba_pkg::IDX_W-1:0]     block_index_i,
  input  logic                          cfg_valid_i,
  input  logic [cba_pkg::BS_W-1:0]      cfg_block_size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [cba_pkg::IDX_W-1:0]     start_index_o,
  output logic [cba_pkg::CNT_W-1:0]     run_length_o,
  output logic [cba_pkg::BYTES_W-1:0]   run_bytes_o
);

  localparam int NUM_BLOCKS = cba_pkg::NUM_BLOCKS;
  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int FW = AW + 1;
  localparam int UW = $clog2(NUM_BLOCKS + 1);
  localparam int CW = cba_pkg::CNT_W;
  localparam int PW = CW + cba_pkg::BS_W;

  // Block table: {used, multi, start, run count}
  logic [cba_pkg::ENT_W-1:0] mem_q [NUM_BLOCKS];
  logic [cba_pkg::ENT_W-1:0] rdata_q;
  logic                      mem_we;
  logic [cba_pkg::ENT_W-1:0] mem_wdata;

  logic [1:0]              func_q;
  logic [CW-1:0]           cnt_q, run_q, run_d, rem_q, rem_d, len_q, len_d;
  logic [cba_pkg::IDX_W-1:0] idx_q;
  logic [AW-1:0]           addr_q, addr_d, start_q, start_d;
  logic [FW-1:0]           ff_q, ff_d;
  logic [UW-1:0]           ut_q, ut_d, ut_free;
  logic [1:0]              rsp_q, rsp_d;
  logic [cba_pkg::BS_W-1:0] bs_q;

  logic                    out_valid_q;
  logic [1:0]              out_status_q;
  logic [cba_pkg::IDX_W-1:0] out_start_q;
  logic [CW-1:0]           out_len_q;
  logic [cba_pkg::BYTES_W-1:0] out_bytes_q;

  logic          rd_used, rd_multi, rd_start;
  logic [CW-1:0] rd_rc;
  logic [CW-1:0] len_cand, len_clip;
  logic [FW-1:0] room;
  logic [PW-1:0] prod;
  logic          at_end;

  assign rd_used  = rdata_q[cba_pkg::ENT_W-1];
  assign rd_multi = rdata_q[cba_pkg::ENT_W-2];
  assign rd_start = rdata_q[cba_pkg::ENT_W-3];
  assign rd_rc    = rdata_q[CW-1:0];
  assign at_end   = (addr_q == AW'(NUM_BLOCKS - 1));

  // Run length at the run's start, clipped to the end of the pool
  assign len_cand = rd_multi ? rd_rc : CW'(1);
  assign room     = FW'(NUM_BLOCKS) - {1'b0, addr_q};
  assign len_clip = ({{(FW > CW ? FW - CW : 0){1'b0}}, len_cand} > FW'(room)) ?
                    CW'(room) : len_cand;

  assign ut_free  = (ut_q > UW'(len_q)) ? ut_q - UW'(len_q) : '0;

  always_comb begin
    st_o.func          = func_q;
    st_o.cnt_bad       = (cnt_q == '0) || (int'(cnt_q) > NUM_BLOCKS);
    st_o.ff_full       = (ff_q >= FW'(NUM_BLOCKS));
    st_o.idx_bad       = (int'(idx_q) >= NUM_BLOCKS);
    st_o.used          = rd_used;
    st_o.start_or_zero = rd_start || (addr_q == '0);
    st_o.run_hit       = !rd_used && (({1'b0, run_q} + 9'd1) == {1'b0, cnt_q});
    st_o.at_end        = at_end;
    st_o.rem_last      = (rem_q <= CW'(1));
    st_o.len_zero      = (len_clip == '0);
    st_o.start_is_ff   = ({1'b0, start_q} == ff_q);
    st_o.out_free      = !out_valid_q || out_ready_i;
  end

  always_comb begin
    addr_d    = addr_q;
    run_d     = run_q;
    rem_d     = rem_q;
    len_d     = len_q;
    start_d   = start_q;
    ff_d      = ff_q;
    ut_d      = ut_q;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_wdata = '0;
    case (cmd_i.op)
      cba_pkg::OP_CLR: begin
        mem_we = 1'b1;
        addr_d = at_end ? '0 : addr_q + AW'(1);
      end
      cba_pkg::OP_LOAD: rsp_d = cba_pkg::ST_OK;
      cba_pkg::OP_ERR_NOSPACE: begin
        rsp_d = cba_pkg::ST_NOSPACE;
        len_d = '0;
        start_d = '0;
      end
      cba_pkg::OP_ERR_BAD: begin
        rsp_d = cba_pkg::ST_BADINDEX;
        len_d = '0;
        start_d = '0;
      end
      cba_pkg::OP_SCAN_INIT: begin
        addr_d = ff_q[AW-1:0];
        run_d  = '0;
      end
      cba_pkg::OP_SCAN_STEP: begin
        run_d  = rd_used ? '0 : run_q + CW'(1);
        addr_d = addr_q + AW'(1);
      end
      cba_pkg::OP_FOUND: begin
        start_d = AW'(int'(addr_q) + 1 - int'(cnt_q));
        addr_d  = AW'(int'(addr_q) + 1 - int'(cnt_q));
        rem_d   = cnt_q;
        len_d   = cnt_q;
      end
      cba_pkg::OP_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, (cnt_q > CW'(1)), (addr_q == start_q),
                     (addr_q == start_q) ? cnt_q : CW'(0)};
        addr_d    = addr_q + AW'(1);
        rem_d     = rem_q - CW'(1);
        if (rem_q == CW'(1)) begin
          ut_d = UW'(ut_q + UW'(cnt_q));
          if (({1'b0, start_q} == ff_q) && at_end) ff_d = FW'(NUM_BLOCKS);
        end
      end
      cba_pkg::OP_NF_STEP: addr_d = addr_q + AW'(1);
      cba_pkg::OP_NF_SET:  ff_d = {1'b0, addr_q};
      cba_pkg::OP_NF_FULL: ff_d = FW'(NUM_BLOCKS);
      cba_pkg::OP_FIND_INIT: addr_d = AW'(idx_q);
      cba_pkg::OP_WALK_BACK: addr_d = addr_q - AW'(1);
      cba_pkg::OP_WALK_DONE: begin
        start_d = addr_q;
        len_d   = len_clip;
        rem_d   = len_clip;
      end
      cba_pkg::OP_REL: begin
        mem_we = 1'b1;
        addr_d = addr_q + AW'(1);
        rem_d  = rem_q - CW'(1);
      end
      cba_pkg::OP_FREE_FIN: begin
        ut_d = ut_free;
        if (ut_free == '0)                ff_d = '0;
        else if ({1'b0, start_q} < ff_q) ff_d = {1'b0, start_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[addr_q] <= mem_wdata;
    rdata_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      ff_q        <= '0;
      ut_q        <= '0;
      bs_q        <= cba_pkg::BLOCK_SIZE_RST;
      out_valid_q <= 1'b0;
    end else begin
      addr_q <= addr_d;
      ff_q   <= ff_d;
      ut_q   <= ut_d;
      if (cfg_valid_i) bs_q <= cfg_block_size_i;
      if (cmd_i.op == cba_pkg::OP_RESP) out_valid_q <= 1'b1;
      else if (out_ready_i)             out_valid_q <= 1'b0;
    end
  end

  assign prod = PW'(len_q) * PW'(bs_q);

  always_ff @(posedge clk_i) begin
    run_q   <= run_d;
    rem_q   <= rem_d;
    len_q   <= len_d;
    start_q <= start_d;
    rsp_q   <= rsp_d;
    if (cmd_i.op == cba_pkg::OP_LOAD) begin
      func_q <= func_i;
      cnt_q  <= count_i;
      idx_q  <= block_index_i;
    end
    if (cmd_i.op == cba_pkg::OP_RESP) begin
      out_status_q <= rsp_q;
      out_start_q  <= cba_pkg::IDX_W'(start_q);
      out_len_q    <= len_q;
      // saturate to the 23-bit byte field
      out_bytes_q  <= (prod > PW'({cba_pkg::BYTES_W{1'b1}})) ?
                      {cba_pkg::BYTES_W{1'b1}} : cba_pkg::BYTES_W'(prod);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign start_index_o = out_start_q;
  assign run_length_o  = out_len_q;
  assign run_bytes_o   = out_bytes_q;

endmodule

### rtl/cba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cba_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  status_o,
  input logic [cba_pkg::IDX_W-1:0]   start_index_o,
  input logic [cba_pkg::CNT_W-1:0]   run_length_o,
  input logic [cba_pkg::BYTES_W-1:0] run_bytes_o
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(run_bytes_o))
  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_valid_o && status_o != cba_pkg::ST_OK, start_index_o == '0 && run_length_o == '0 && run_bytes_o == '0)
  `ASSERT_IMPL(a_status_code, clk_i, rst_ni, out_valid_o, status_o <= cba_pkg::ST_BADINDEX)
  `ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind contiguous_block_allocator_unit cba_checker u_cba_checker (.*);
